[rtl/block_ring_store_manager_core_assert.svh]
// Assertion helpers for the ring store manager.
`ifndef BLOCK_RING_STORE_MANAGER_CORE_ASSERT_SVH
`define BLOCK_RING_STORE_MANAGER_CORE_ASSERT_SVH

// Checked outside reset.
`define BRSM_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define BRSM_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/brsm_pkg.sv]
`default_nettype none
package brsm_pkg;

    localparam int SEQ_MODULUS      = 100;
    localparam int MIN_BLOCKS       = 2;
    localparam int MAX_BLOCKS_LIMIT = 99;
    localparam int SIZE_BITS        = 24;

    localparam int SEQ_W    = 7;
    localparam int POL_W    = 2;
    localparam int USED_W   = 31;
    localparam int ACT_W    = 3;
    localparam int PROD_W   = SEQ_W + SIZE_BITS;
    localparam int DATA_W   = 80;
    localparam int APB_AW   = 4;
    localparam int APB_DW   = 32;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam logic [SEQ_W-1:0] SEQ_LAST   = SEQ_W'(SEQ_MODULUS - 1);
    localparam logic [SEQ_W-1:0] SEQ_MOD_V  = SEQ_W'(SEQ_MODULUS);
    localparam logic [SEQ_W-1:0] BLOCKS_MIN = SEQ_W'(MIN_BLOCKS);
    localparam logic [SEQ_W-1:0] BLOCKS_MAX = SEQ_W'(MAX_BLOCKS_LIMIT);

    typedef enum logic [ACT_W-1:0] {
        ACT_PREPARE   = 3'd0,
        ACT_RECORD    = 3'd1,
        ACT_CORRUPT   = 3'd2,
        ACT_CURSOR    = 3'd3,
        ACT_DRAIN     = 3'd4,
        ACT_NEXT_READ = 3'd5,
        ACT_NOP       = 3'd6
    } t_action;

    typedef enum logic [POL_W-1:0] {
        POL_OLDEST = 2'd0,
        POL_HALT   = 2'd1,
        POL_REJECT = 2'd2
    } t_policy;

    typedef enum logic [1:0] {
        REG_MAX_BLOCKS = 2'd0,
        REG_BLOCK_SIZE = 2'd1,
        REG_POLICY     = 2'd2,
        REG_THRESHOLD  = 2'd3
    } t_reg_idx;

    typedef struct packed {
        logic [SEQ_W-1:0]     max_blocks;
        logic [SIZE_BITS-1:0] block_size;
        logic [POL_W-1:0]     policy;
        logic [USED_W-1:0]    threshold;
    } t_cfg;

    typedef struct packed {
        t_action              action;
        logic [SIZE_BITS-1:0] record_size;
        logic [SIZE_BITS-1:0] cursor;
        logic                 acquire_ok;
        logic                 discard_ok;
        logic                 drain_ok;
        logic [SIZE_BITS-1:0] read_block_size;
    } t_item;

    // post-action state handed from the executer to the reporting stages
    typedef struct packed {
        logic                 space;
        logic                 changed;
        logic                 pulse_full;
        logic                 halted;
        logic                 check;
        logic                 at_cap;
        logic [SEQ_W-1:0]     closed;
        logic [SEQ_W-1:0]     write_block;
        logic [SEQ_W-1:0]     read_block;
        logic [SIZE_BITS-1:0] read_pos;
        logic [SIZE_BITS-1:0] write_pos;
    } t_snap;

    typedef struct packed {
        logic [USED_W-1:0]    used_bytes;
        logic                 has_unsent;
        logic [SIZE_BITS-1:0] read_offset;
        logic [SEQ_W-1:0]     read_block;
        logic [SEQ_W-1:0]     write_block;
        logic                 is_halted;
        logic                 store_full_event;
        logic                 threshold_event;
        logic                 read_block_changed;
        logic                 space_available;
    } t_result;

    function automatic logic [SEQ_W-1:0] seq_next(input logic [SEQ_W-1:0] s);
        return (s == SEQ_LAST) ? '0 : SEQ_W'(s + 1'b1);
    endfunction

    // distance from oldest to write block, modulo the sequence range
    function automatic logic [SEQ_W-1:0] ring_dist(input logic [SEQ_W-1:0] w,
                                                   input logic [SEQ_W-1:0] o);
        return (w >= o) ? SEQ_W'(w - o) : SEQ_W'(w + SEQ_MOD_V - o);
    endfunction

    function automatic logic [SEQ_W-1:0] blocks_limit(input logic [SEQ_W-1:0] m);
        if (m < BLOCKS_MIN) begin
            return BLOCKS_MIN;
        end else if (m > BLOCKS_MAX) begin
            return BLOCKS_MAX;
        end
        return m;
    endfunction

endpackage
`default_nettype wire

[rtl/brsm_front.sv]
`default_nettype none
module brsm_front
    import brsm_pkg::*;
(
    input  wire logic              i_s_tvalid,
    input  wire logic [DATA_W-1:0] i_s_tdata,
    input  wire logic [ACT_W-1:0]  i_s_tuser,
    input  wire logic              i_full,
    output logic                   o_s_tready,
    output logic                   o_push,
    output t_item                  o_item
);

    t_action act;

    always_comb begin
        case (i_s_tuser)
            ACT_PREPARE:   act = ACT_PREPARE;
            ACT_RECORD:    act = ACT_RECORD;
            ACT_CORRUPT:   act = ACT_CORRUPT;
            ACT_CURSOR:    act = ACT_CURSOR;
            ACT_DRAIN:     act = ACT_DRAIN;
            ACT_NEXT_READ: act = ACT_NEXT_READ;
            default:       act = ACT_NOP;
        endcase
    end

    always_comb begin
        o_item.action          = act;
        o_item.record_size     = i_s_tdata[SIZE_BITS-1:0];
        o_item.cursor          = i_s_tdata[2*SIZE_BITS-1:SIZE_BITS];
        o_item.acquire_ok      = i_s_tdata[2*SIZE_BITS];
        o_item.discard_ok      = i_s_tdata[2*SIZE_BITS+1];
        o_item.drain_ok        = i_s_tdata[2*SIZE_BITS+2];
        o_item.read_block_size = i_s_tdata[3*SIZE_BITS+2:2*SIZE_BITS+3];
    end

    assign o_s_tready = !i_full;
    assign o_push     = i_s_tvalid && !i_full;

endmodule
`default_nettype wire

[rtl/brsm_queue.sv]
`default_nettype none
module brsm_queue
    import brsm_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  t_item     i_item,
    input  wire logic i_pop,
    output logic      o_full,
    output logic      o_valid,
    output t_item     o_item
);

    t_item              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  r_wr_ptr;
    logic [QPTR_W-1:0]  r_rd_ptr;
    logic [QPTR_W:0]    r_count;
    logic               do_pop;

    assign do_pop  = i_pop && (r_count != '0);
    assign o_full  = (r_count == (QPTR_W+1)'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= QPTR_W'(r_wr_ptr + 1'b1);
            end
            if (do_pop) begin
                r_rd_ptr <= QPTR_W'(r_rd_ptr + 1'b1);
            end
            case ({i_push, do_pop})
                2'b10:   r_count <= (QPTR_W+1)'(r_count + 1'b1);
                2'b01:   r_count <= (QPTR_W+1)'(r_count - 1'b1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule
`default_nettype wire

[rtl/brsm_exec.sv]
`default_nettype none
module brsm_exec
    import brsm_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  t_cfg      i_cfg,
    input  wire logic i_q_valid,
    input  t_item     i_q_item,
    input  wire logic i_advance,
    output logic      o_pop,
    output logic      o_snap_valid,
    output t_snap     o_snap
);

    logic [SEQ_W-1:0]     r_oldest, n_oldest;
    logic [SEQ_W-1:0]     r_wblk, n_wblk;
    logic [SEQ_W-1:0]     r_rblk, n_rblk;
    logic [SIZE_BITS-1:0] r_rpos, n_rpos;
    logic [SIZE_BITS-1:0] r_wpos, n_wpos;
    logic                 r_corrupt, n_corrupt;
    logic                 r_at_cap, n_at_cap;
    logic                 r_halted, n_halted;
    logic                 r_snap_valid;
    t_snap                r_snap, n_snap;

    logic [SEQ_W-1:0]     limit, ring_span, ring_span1, w1, o1, r1;
    logic [SIZE_BITS-1:0] rp1;
    logic [SIZE_BITS:0]   wsum;
    logic                 full, ring_full, over, discard, rd_old, drain1, drain0;
    logic                 space, changed, pfull, check;
    logic                 step;

    assign step  = i_advance && i_q_valid;
    assign o_pop = step;

    function automatic logic can_drain(input logic [SEQ_W-1:0] r, input logic [SEQ_W-1:0] w,
                                       input logic [SEQ_W-1:0] o,
                                       input logic [SIZE_BITS-1:0] rpos,
                                       input logic [SIZE_BITS-1:0] sz, input logic ok);
        return (r != w) && (r == o) && (rpos >= sz) && ok;
    endfunction

    always_comb begin
        limit     = blocks_limit(i_cfg.max_blocks);
        ring_span = ring_dist(r_wblk, r_oldest);
        wsum      = {1'b0, r_wpos} + {1'b0, i_q_item.record_size};
        full      = r_corrupt || (wsum > {1'b0, i_cfg.block_size});
        ring_full = ({1'b0, ring_span} + 1'b1) >= {1'b0, limit};

        // rotation path: new write block, then optional discard of the oldest
        w1         = seq_next(r_wblk);
        ring_span1 = seq_next(ring_span);
        over       = ({1'b0, ring_span1} + 1'b1) > {1'b0, limit};
        discard    = over && i_q_item.discard_ok;
        rd_old     = (r_rblk == r_oldest);
        o1         = discard ? seq_next(r_oldest) : r_oldest;
        r1         = (discard && rd_old) ? o1 : r_rblk;
        rp1        = (discard && rd_old) ? '0 : r_rpos;
        drain1     = can_drain(r1, w1, o1, rp1, i_q_item.read_block_size, i_q_item.drain_ok);
        drain0     = can_drain(r_rblk, r_wblk, r_oldest, r_rpos, i_q_item.read_block_size,
                               i_q_item.drain_ok);
    end

    always_comb begin
        n_oldest  = r_oldest;
        n_wblk    = r_wblk;
        n_rblk    = r_rblk;
        n_rpos    = r_rpos;
        n_wpos    = r_wpos;
        n_corrupt = r_corrupt;
        n_at_cap  = r_at_cap;
        n_halted  = r_halted;
        space     = 1'b0;
        changed   = 1'b0;
        pfull     = 1'b0;
        check     = 1'b0;
        case (i_q_item.action)
            ACT_PREPARE: begin
                if (full && ring_full && (i_cfg.policy != POL_OLDEST)) begin
                    n_at_cap = 1'b1;
                    check    = 1'b1;
                    if ((i_cfg.policy == POL_HALT) && !r_halted) begin
                        n_halted = 1'b1;
                        pfull    = 1'b1;
                    end
                end else if (full) begin
                    if (i_q_item.acquire_ok) begin
                        n_wblk    = w1;
                        n_wpos    = '0;
                        n_corrupt = 1'b0;
                        n_oldest  = o1;
                        n_rblk    = r1;
                        n_rpos    = rp1;
                        changed   = discard && rd_old;
                        if (drain1) begin
                            n_oldest = seq_next(o1);
                            n_rblk   = seq_next(o1);
                            n_rpos   = '0;
                            check    = 1'b1;
                            changed  = 1'b1;
                        end
                    end
                    space = i_q_item.acquire_ok;
                end else begin
                    space = 1'b1;
                end
            end
            ACT_RECORD: begin
                n_wpos = wsum[SIZE_BITS] ? '1 : wsum[SIZE_BITS-1:0];
                check  = 1'b1;
            end
            ACT_CORRUPT: begin
                n_corrupt = 1'b1;
            end
            ACT_CURSOR: begin
                n_rpos = i_q_item.cursor;
            end
            ACT_DRAIN: begin
                if (drain0) begin
                    n_oldest = seq_next(r_oldest);
                    n_rblk   = seq_next(r_oldest);
                    n_rpos   = '0;
                    check    = 1'b1;
                    changed  = 1'b1;
                end
            end
            ACT_NEXT_READ: begin
                n_rblk = seq_next(r_rblk);
                n_rpos = '0;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        n_snap.space       = space;
        n_snap.changed     = changed;
        n_snap.pulse_full  = pfull;
        n_snap.halted      = n_halted;
        n_snap.check       = check;
        n_snap.at_cap      = n_at_cap;
        n_snap.closed      = ring_dist(n_wblk, n_oldest);
        n_snap.write_block = n_wblk;
        n_snap.read_block  = n_rblk;
        n_snap.read_pos    = n_rpos;
        n_snap.write_pos   = n_wpos;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_oldest     <= '0;
            r_wblk       <= '0;
            r_rblk       <= '0;
            r_rpos       <= '0;
            r_wpos       <= '0;
            r_corrupt    <= 1'b0;
            r_at_cap     <= 1'b0;
            r_halted     <= 1'b0;
            r_snap_valid <= 1'b0;
        end else if (i_advance) begin
            r_snap_valid <= i_q_valid;
            if (step) begin
                r_oldest  <= n_oldest;
                r_wblk    <= n_wblk;
                r_rblk    <= n_rblk;
                r_rpos    <= n_rpos;
                r_wpos    <= n_wpos;
                r_corrupt <= n_corrupt;
                r_at_cap  <= n_at_cap;
                r_halted  <= n_halted;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_snap <= n_snap;
        end
    end

    assign o_snap_valid = r_snap_valid;
    assign o_snap       = r_snap;

endmodule
`default_nettype wire

[rtl/brsm_report.sv]
`default_nettype none
module brsm_report
    import brsm_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  t_cfg      i_cfg,
    input  wire logic i_snap_valid,
    input  t_snap     i_snap,
    input  wire logic i_m_tready,
    output logic      o_advance,
    output logic      o_m_tvalid,
    output t_result   o_result
);

    logic                 r_b_valid;
    t_snap                r_b_snap;
    logic [PROD_W-1:0]    r_b_prod;
    logic [SIZE_BITS-1:0] r_b_add;
    logic                 r_b_unsent;
    logic                 r_thr_flag;
    logic                 r_out_valid;
    t_result              r_out, n_out;

    logic [SEQ_W-1:0]     mult_a;
    logic [USED_W-1:0]    used;
    logic                 above;
    logic                 adv;

    assign adv       = !r_out_valid || i_m_tready;
    assign o_advance = adv;

    assign mult_a = i_snap.at_cap ? blocks_limit(i_cfg.max_blocks) : i_snap.closed;

    always_comb begin
        used  = USED_W'(r_b_prod + PROD_W'(r_b_add));
        above = (i_cfg.threshold != '0) && (used >= i_cfg.threshold);

        n_out.used_bytes         = used;
        n_out.has_unsent         = r_b_unsent;
        n_out.read_offset        = r_b_snap.read_pos;
        n_out.read_block         = r_b_snap.read_block;
        n_out.write_block        = r_b_snap.write_block;
        n_out.is_halted          = r_b_snap.halted;
        n_out.store_full_event   = r_b_snap.pulse_full;
        n_out.threshold_event    = r_b_snap.check && above && !r_thr_flag;
        n_out.read_block_changed = r_b_snap.changed;
        n_out.space_available    = r_b_snap.space;
    end

    always_ff @(posedge i_clk) begin
        if (adv && i_snap_valid) begin
            r_b_snap   <= i_snap;
            r_b_prod   <= PROD_W'(mult_a) * PROD_W'(i_cfg.block_size);
            r_b_add    <= i_snap.at_cap ? '0 : i_snap.write_pos;
            r_b_unsent <= (i_snap.read_block != i_snap.write_block) ||
                          (i_snap.read_pos < i_snap.write_pos);
        end
        if (adv && r_b_valid) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid   <= 1'b0;
            r_out_valid <= 1'b0;
            r_thr_flag  <= 1'b0;
        end else if (adv) begin
            r_b_valid   <= i_snap_valid;
            r_out_valid <= r_b_valid;
            if (r_b_valid && r_b_snap.check) begin
                r_thr_flag <= above;
            end
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_result   = r_out;

endmodule
`default_nettype wire

[rtl/block_ring_store_manager_core.sv]
// Block ring store manager.
// Input stream (s_axis): one action per transaction. tuser carries the action
// code, tdata the record size, cursor, device status bits and read block size.
// Output stream (m_axis): one status transaction per accepted action, in order:
// flags, write/read block numbers, read cursor, unsent flag and used bytes.
// APB port: four registers at byte offsets 0, 4, 8, 12; pready is tied high.
// Registers must be written by the user only while no action is in flight; the
// block does not enforce this. Throughput: one action per cycle while the
// receiver does not stall. The executer updates the ring pointers; the used-byte
// multiply and the threshold compare run in the two stages after it, so the
// threshold flag is the only state they carry. A 4-entry queue sits between the
// input side and the executer.
// Reset: ring pointers, positions and all flags clear; registers take their
// defaults (2 blocks, 4096 bytes, discard oldest, threshold off).
// Receiver stall: the output holds its transaction, the pipeline freezes, the
// queue fills and s_axis_tready drops once it is full.
`default_nettype none
module block_ring_store_manager_core
    import brsm_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    // APB configuration
    input  wire logic              i_psel,
    input  wire logic              i_penable,
    input  wire logic              i_pwrite,
    input  wire logic [APB_AW-1:0] i_paddr,
    input  wire logic [APB_DW-1:0] i_pwdata,
    output logic      [APB_DW-1:0] o_prdata,
    output logic                   o_pready,
    // input stream
    input  wire logic              i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    // record_size[23:0], cursor[47:24], acquire_ok[48], discard_ok[49],
    // drain_dispose_ok[50], read_block_size[74:51], zero[79:75]
    input  wire logic [DATA_W-1:0] i_s_axis_tdata,
    // action[2:0]
    input  wire logic [ACT_W-1:0]  i_s_axis_tuser,
    // output stream
    output logic                   o_m_axis_tvalid,
    input  wire logic              i_m_axis_tready,
    // space_available[0], read_block_changed[1], threshold_event[2],
    // store_full_event[3], is_halted[4], write_block[11:5], read_block[18:12],
    // read_offset[42:19], has_unsent[43], used_bytes[74:44], zero[79:75]
    output logic      [DATA_W-1:0] o_m_axis_tdata
);

    t_cfg     r_cfg;
    t_reg_idx reg_idx;
    logic     cfg_wr;

    t_item    front_item, q_item;
    logic     push, q_full, q_valid, pop, advance, snap_valid;
    t_snap    snap;
    t_result  result;

    assign o_pready = 1'b1;
    assign reg_idx  = t_reg_idx'(i_paddr[APB_AW-1:2]);
    assign cfg_wr   = i_psel && i_penable && i_pwrite && (i_paddr[1:0] == 2'b00 ||
                      i_paddr[1:0] != 2'b00);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.max_blocks <= SEQ_W'(MIN_BLOCKS);
            r_cfg.block_size <= SIZE_BITS'(4096);
            r_cfg.policy     <= POL_OLDEST;
            r_cfg.threshold  <= '0;
        end else if (cfg_wr) begin
            case (reg_idx)
                REG_MAX_BLOCKS: r_cfg.max_blocks <= i_pwdata[SEQ_W-1:0];
                REG_BLOCK_SIZE: r_cfg.block_size <= i_pwdata[SIZE_BITS-1:0];
                REG_POLICY:     r_cfg.policy     <= i_pwdata[POL_W-1:0];
                REG_THRESHOLD:  r_cfg.threshold  <= i_pwdata[USED_W-1:0];
                default:        r_cfg            <= r_cfg;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_MAX_BLOCKS: o_prdata = APB_DW'(r_cfg.max_blocks);
            REG_BLOCK_SIZE: o_prdata = APB_DW'(r_cfg.block_size);
            REG_POLICY:     o_prdata = APB_DW'(r_cfg.policy);
            REG_THRESHOLD:  o_prdata = APB_DW'(r_cfg.threshold);
            default:        o_prdata = '0;
        endcase
    end

    brsm_front u_front (
        .i_s_tvalid (i_s_axis_tvalid),
        .i_s_tdata  (i_s_axis_tdata),
        .i_s_tuser  (i_s_axis_tuser),
        .i_full     (q_full),
        .o_s_tready (o_s_axis_tready),
        .o_push     (push),
        .o_item     (front_item)
    );

    brsm_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (front_item),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_item  (q_item)
    );

    brsm_exec u_exec (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_q_valid    (q_valid),
        .i_q_item     (q_item),
        .i_advance    (advance),
        .o_pop        (pop),
        .o_snap_valid (snap_valid),
        .o_snap       (snap)
    );

    brsm_report u_report (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_snap_valid (snap_valid),
        .i_snap       (snap),
        .i_m_tready   (i_m_axis_tready),
        .o_advance    (advance),
        .o_m_tvalid   (o_m_axis_tvalid),
        .o_result     (result)
    );

    assign o_m_axis_tdata = {(DATA_W - $bits(t_result))'(0), result};

endmodule
`default_nettype wire

[rtl/brsm_checker.sv]
`default_nettype none
`include "block_ring_store_manager_core_assert.svh"
module brsm_checker
    import brsm_pkg::*;
(
    input wire logic              i_clk,
    input wire logic              i_rst_n,
    input wire logic              i_m_axis_tvalid,
    input wire logic              i_m_axis_tready,
    input wire logic [DATA_W-1:0] i_m_axis_tdata
);

    logic r_seen_halted;
    logic out_xfer;

    assign out_xfer = i_m_axis_tvalid && i_m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen_halted <= 1'b0;
        end else if (out_xfer && i_m_axis_tdata[4]) begin
            r_seen_halted <= 1'b1;
        end
    end

    `BRSM_ASSERT(a_out_hold, i_clk, i_rst_n, i_m_axis_tvalid && !i_m_axis_tready |=> i_m_axis_tvalid && $stable(i_m_axis_tdata), "stalled output transaction changed")
    `BRSM_ASSERT(a_full_halts, i_clk, i_rst_n, i_m_axis_tvalid && i_m_axis_tdata[3] |-> i_m_axis_tdata[4], "store full event without halted flag")
    `BRSM_ASSERT(a_halt_sticky, i_clk, i_rst_n, i_m_axis_tvalid && r_seen_halted |-> i_m_axis_tdata[4], "halted flag dropped after being reported")
    `BRSM_ASSERT_ALWAYS(a_reset_idle, i_clk, !i_rst_n |=> !i_m_axis_tvalid, "output valid right after reset")

endmodule

bind block_ring_store_manager_core brsm_checker u_brsm_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .i_m_axis_tdata  (o_m_axis_tdata)
);
`default_nettype wire

[bench/tb_block_ring_store_manager_core.sv]
module tb_block_ring_store_manager_core;
    import brsm_pkg::*;

    localparam logic [ACT_W-1:0] ACT_UNUSED   = 3'd7;
    localparam logic [POL_W-1:0] POL_RESERVED = 2'd3;
    localparam int RANDOM_PER_PHASE = 85;
    localparam int PHASES = 6;

    typedef struct packed {
        logic [ACT_W-1:0]     action;
        logic [SIZE_BITS-1:0] record_size;
        logic [SIZE_BITS-1:0] cursor;
        logic                 acquire_ok;
        logic                 discard_ok;
        logic                 drain_ok;
        logic [SIZE_BITS-1:0] read_block_size;
    } act_req;

    typedef struct {
        act_req  req;
        bit      fixed;
        t_result want;
    } script_row;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [APB_AW-1:0] paddr = '0;
    logic [APB_DW-1:0] pwdata = '0;
    wire  [APB_DW-1:0] prdata;
    wire               pready;
    logic              s_valid = 1'b0;
    wire               s_ready;
    logic [DATA_W-1:0] s_data = '0;
    logic [ACT_W-1:0]  s_user = '0;
    wire               m_valid;
    logic              m_ready = 1'b0;
    wire  [DATA_W-1:0] m_data;

    block_ring_store_manager_core dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_psel          (psel),
        .i_penable       (penable),
        .i_pwrite        (pwrite),
        .i_paddr         (paddr),
        .i_pwdata        (pwdata),
        .o_prdata        (prdata),
        .o_pready        (pready),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .i_s_axis_tuser  (s_user),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data)
    );

    always #1 i_clk = ~i_clk;

    // ring model state
    logic [SEQ_W-1:0]     cfg_blocks = 7'd2;
    logic [SIZE_BITS-1:0] cfg_bsize = 24'd4096;
    logic [POL_W-1:0]     cfg_policy = POL_OLDEST;
    logic [USED_W-1:0]    cfg_thresh = '0;
    logic [SEQ_W-1:0]     oldest_q = '0;
    logic [SEQ_W-1:0]     wr_blk = '0;
    logic [SEQ_W-1:0]     rd_blk = '0;
    logic [SIZE_BITS-1:0] rd_pos = '0;
    logic [SIZE_BITS-1:0] wr_pos = '0;
    bit wr_corrupt, full_ring, halted, thr_seen, thr_pulse;

    t_result   status_due[$];
    script_row script[$];
    t_cfg      plan[PHASES];
    bit tx_burst, rx_burst;
    int rx_hold;
    int mismatches, statuses_seen, sent;

    function automatic int pick_wait(inout bit burst);
        if ($urandom_range(0, 19) == 0) burst = !burst;
        return burst ? 0 : $urandom_range(0, 15);
    endfunction

    function automatic logic [SEQ_W-1:0] seq_inc(input logic [SEQ_W-1:0] s);
        return SEQ_W'((int'(s) + 1) % SEQ_MODULUS);
    endfunction

    function automatic int blk_cap();
        if (cfg_blocks < MIN_BLOCKS) return MIN_BLOCKS;
        if (cfg_blocks > MAX_BLOCKS_LIMIT) return MAX_BLOCKS_LIMIT;
        return int'(cfg_blocks);
    endfunction

    function automatic int ring_len();
        return (int'(wr_blk) + SEQ_MODULUS - int'(oldest_q)) % SEQ_MODULUS + 1;
    endfunction

    function automatic logic [USED_W-1:0] used_calc();
        longint u;
        if (full_ring) u = longint'(blk_cap()) * longint'(cfg_bsize);
        else u = longint'(ring_len() - 1) * longint'(cfg_bsize) + longint'(wr_pos);
        return u[USED_W-1:0];
    endfunction

    function automatic void eval_threshold();
        bit above;
        above = (cfg_thresh != 0) && (used_calc() >= cfg_thresh);
        if (!above) begin
            thr_seen = 1'b0;
        end else if (!thr_seen) begin
            thr_seen = 1'b1;
            thr_pulse = 1'b1;
        end
    endfunction

    function automatic bit try_drain(input logic [SIZE_BITS-1:0] size_now, input bit ok);
        if (rd_blk != wr_blk && rd_blk == oldest_q && rd_pos >= size_now && ok) begin
            oldest_q = seq_inc(oldest_q);
            rd_blk = oldest_q;
            rd_pos = '0;
            eval_threshold();
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic t_result predict_action(input act_req r);
        t_result res;
        bit no_room, moved, took;
        logic [SIZE_BITS:0] sum;
        res = '0;
        moved = 1'b0;
        thr_pulse = 1'b0;
        case (r.action)
            ACT_PREPARE: begin
                no_room = wr_corrupt || ({1'b0, wr_pos} + {1'b0, r.record_size} > {1'b0, cfg_bsize});
                if (no_room && ring_len() >= blk_cap() && cfg_policy != POL_OLDEST) begin
                    full_ring = 1'b1;
                    eval_threshold();
                    if (cfg_policy == POL_HALT && !halted) begin
                        halted = 1'b1;
                        res.store_full_event = 1'b1;
                    end
                end else if (no_room) begin
                    if (r.acquire_ok) begin
                        wr_blk = seq_inc(wr_blk);
                        wr_pos = '0;
                        wr_corrupt = 1'b0;
                        if (ring_len() > blk_cap() && r.discard_ok) begin
                            took = (rd_blk == oldest_q);
                            oldest_q = seq_inc(oldest_q);
                            if (took) begin
                                rd_blk = oldest_q;
                                rd_pos = '0;
                                moved = 1'b1;
                            end
                        end
                        if (try_drain(r.read_block_size, r.drain_ok)) moved = 1'b1;
                    end
                    res.space_available = r.acquire_ok;
                end else begin
                    res.space_available = 1'b1;
                end
            end
            ACT_RECORD: begin
                sum = wr_pos + r.record_size;
                wr_pos = sum[SIZE_BITS] ? '1 : sum[SIZE_BITS-1:0];
                eval_threshold();
            end
            ACT_CORRUPT: wr_corrupt = 1'b1;
            ACT_CURSOR: rd_pos = r.cursor;
            ACT_DRAIN: moved = try_drain(r.read_block_size, r.drain_ok);
            ACT_NEXT_READ: begin
                rd_blk = seq_inc(rd_blk);
                rd_pos = '0;
            end
            default: ;
        endcase
        res.read_block_changed = moved;
        res.threshold_event = thr_pulse;
        res.is_halted = halted;
        res.write_block = wr_blk;
        res.read_block = rd_blk;
        res.read_offset = rd_pos;
        res.has_unsent = (rd_blk != wr_blk) || (rd_pos < wr_pos);
        res.used_bytes = used_calc();
        return res;
    endfunction

    function automatic act_req req_of(input logic [ACT_W-1:0] act,
                                      input logic [SIZE_BITS-1:0] rsize,
                                      input logic [SIZE_BITS-1:0] cur,
                                      input bit acq, input bit disc, input bit drain,
                                      input logic [SIZE_BITS-1:0] rbs);
        act_req r;
        r = '{act, rsize, cur, acq, disc, drain, rbs};
        return r;
    endfunction

    function automatic t_result status_of(input bit space, input bit changed, input bit thr,
                                          input bit full, input bit hlt,
                                          input logic [SEQ_W-1:0] wblk,
                                          input logic [SEQ_W-1:0] rblk,
                                          input logic [SIZE_BITS-1:0] roff,
                                          input bit unsent, input logic [USED_W-1:0] used);
        t_result s;
        s.space_available = space;
        s.read_block_changed = changed;
        s.threshold_event = thr;
        s.store_full_event = full;
        s.is_halted = hlt;
        s.write_block = wblk;
        s.read_block = rblk;
        s.read_offset = roff;
        s.has_unsent = unsent;
        s.used_bytes = used;
        return s;
    endfunction

    // random action, biased toward sizes that hit block boundaries and drains that succeed
    function automatic act_req draw_req();
        act_req r;
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 30) r.action = ACT_PREPARE;
        else if (pick < 52) r.action = ACT_RECORD;
        else if (pick < 57) r.action = ACT_CORRUPT;
        else if (pick < 67) r.action = ACT_CURSOR;
        else if (pick < 82) r.action = ACT_DRAIN;
        else if (pick < 94) r.action = ACT_NEXT_READ;
        else if (pick < 97) r.action = ACT_NOP;
        else r.action = ACT_UNUSED;
        case ($urandom_range(0, 3))
            0: r.record_size = SIZE_BITS'($urandom);
            1: r.record_size = SIZE_BITS'($urandom_range(0, cfg_bsize));
            2: r.record_size = cfg_bsize - wr_pos;
            default: r.record_size = SIZE_BITS'($urandom_range(0, 15));
        endcase
        case ($urandom_range(0, 2))
            0: r.cursor = SIZE_BITS'($urandom);
            1: r.cursor = wr_pos;
            default: r.cursor = SIZE_BITS'($urandom_range(0, 15));
        endcase
        r.acquire_ok = ($urandom_range(0, 4) != 0);
        r.discard_ok = ($urandom_range(0, 3) != 0);
        r.drain_ok = ($urandom_range(0, 2) != 0);
        case ($urandom_range(0, 3))
            0: r.read_block_size = '0;
            1: r.read_block_size = SIZE_BITS'($urandom);
            2: r.read_block_size = rd_pos;
            default: r.read_block_size = rd_pos + 1'b1;
        endcase
        return r;
    endfunction

    task automatic flag_mismatch(input string msg);
        mismatches++;
        if (mismatches <= 40) $display("status %0d: %s", statuses_seen, msg);
    endtask

    task automatic send_action(input act_req r, input bit fixed, input t_result want);
        int gap;
        t_result due;
        gap = pick_wait(tx_burst);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_valid <= 1'b1;
        s_data <= {5'd0, r.read_block_size, r.drain_ok, r.discard_ok, r.acquire_ok,
                   r.cursor, r.record_size};
        s_user <= r.action;
        @(posedge i_clk);
        while (!s_ready) @(posedge i_clk);
        due = predict_action(r);
        status_due.push_back(fixed ? want : due);
        sent++;
    endtask

    task automatic apb_write(input t_reg_idx idx, input logic [APB_DW-1:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_MAX_BLOCKS: cfg_blocks = value[SEQ_W-1:0];
            REG_BLOCK_SIZE: cfg_bsize = value[SIZE_BITS-1:0];
            REG_POLICY: cfg_policy = value[POL_W-1:0];
            REG_THRESHOLD: cfg_thresh = value[USED_W-1:0];
            default: ;
        endcase
    endtask

    task automatic settle();
        s_valid <= 1'b0;
        while (status_due.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // receiver: random stall after each accepted status
    always @(posedge i_clk) begin : rx_side
        int w;
        if (!i_rst_n) begin
            m_ready <= 1'b0;
            rx_hold <= 0;
        end else if (m_valid && m_ready) begin
            w = pick_wait(rx_burst);
            rx_hold <= w;
            m_ready <= (w == 0);
        end else if (rx_hold != 0) begin
            rx_hold <= rx_hold - 1;
            m_ready <= (rx_hold == 1);
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin : status_check
        t_result got, want;
        if (i_rst_n && m_valid && m_ready) begin
            got = t_result'(m_data[$bits(t_result)-1:0]);
            statuses_seen++;
            if (status_due.size() == 0) begin
                flag_mismatch("transaction with nothing expected");
            end else begin
                want = status_due.pop_front();
                if (got.space_available !== want.space_available)
                    flag_mismatch($sformatf("space_available %0d, expected %0d",
                                            got.space_available, want.space_available));
                if (got.read_block_changed !== want.read_block_changed)
                    flag_mismatch($sformatf("read_block_changed %0d, expected %0d",
                                            got.read_block_changed, want.read_block_changed));
                if (got.threshold_event !== want.threshold_event)
                    flag_mismatch($sformatf("threshold_event %0d, expected %0d",
                                            got.threshold_event, want.threshold_event));
                if (got.store_full_event !== want.store_full_event)
                    flag_mismatch($sformatf("store_full_event %0d, expected %0d",
                                            got.store_full_event, want.store_full_event));
                if (got.is_halted !== want.is_halted)
                    flag_mismatch($sformatf("is_halted %0d, expected %0d",
                                            got.is_halted, want.is_halted));
                if (got.write_block !== want.write_block)
                    flag_mismatch($sformatf("write_block %0d, expected %0d",
                                            got.write_block, want.write_block));
                if (got.read_block !== want.read_block)
                    flag_mismatch($sformatf("read_block %0d, expected %0d",
                                            got.read_block, want.read_block));
                if (got.read_offset !== want.read_offset)
                    flag_mismatch($sformatf("read_offset %0d, expected %0d",
                                            got.read_offset, want.read_offset));
                if (got.has_unsent !== want.has_unsent)
                    flag_mismatch($sformatf("has_unsent %0d, expected %0d",
                                            got.has_unsent, want.has_unsent));
                if (got.used_bytes !== want.used_bytes)
                    flag_mismatch($sformatf("used_bytes %0d, expected %0d",
                                            got.used_bytes, want.used_bytes));
            end
        end
    end

    initial begin
        #400000;
        $display("tb_block_ring_store_manager_core: FAIL");
        $finish;
    end

    initial begin : stim
        int directed;
        // reset defaults: 2 blocks of 4096 bytes, discard oldest, threshold off
        script.push_back('{req_of(ACT_NOP, 0, 0, 0, 0, 0, 0), 1'b1,
                           status_of(0, 0, 0, 0, 0, 0, 0, 0, 0, 0)});
        script.push_back('{req_of(ACT_UNUSED, '1, '1, 1, 1, 1, '1), 1'b1,
                           status_of(0, 0, 0, 0, 0, 0, 0, 0, 0, 0)});
        script.push_back('{req_of(ACT_PREPARE, 4096, 0, 0, 0, 0, 0), 1'b1,
                           status_of(1, 0, 0, 0, 0, 0, 0, 0, 0, 0)});
        script.push_back('{req_of(ACT_RECORD, 4096, 0, 0, 0, 0, 0), 1'b1,
                           status_of(0, 0, 0, 0, 0, 0, 0, 0, 1, 4096)});
        // rotation; drained read block goes with it
        script.push_back('{req_of(ACT_PREPARE, 1, 0, 1, 1, 1, 0), 1'b1,
                           status_of(1, 1, 0, 0, 0, 1, 1, 0, 0, 0)});
        // write position saturates
        script.push_back('{req_of(ACT_RECORD, '1, 0, 0, 0, 0, 0), 1'b1,
                           status_of(0, 0, 0, 0, 0, 1, 1, 0, 1, 16777215)});
        script.push_back('{req_of(ACT_RECORD, '1, 0, 0, 0, 0, 0), 1'b1,
                           status_of(0, 0, 0, 0, 0, 1, 1, 0, 1, 16777215)});
        script.push_back('{req_of(ACT_CURSOR, 0, '1, 0, 0, 0, 0), 1'b1,
                           status_of(0, 0, 0, 0, 0, 1, 1, '1, 0, 16777215)});
        script.push_back('{req_of(ACT_CORRUPT, 0, 0, 0, 0, 0, 0), 1'b0, '0});
        script.push_back('{req_of(ACT_PREPARE, 0, 0, 0, 1, 1, 0), 1'b0, '0});
        script.push_back('{req_of(ACT_PREPARE, 0, 0, 1, 0, 0, 0), 1'b0, '0});
        script.push_back('{req_of(ACT_PREPARE, 5000, 0, 1, 1, 0, 0), 1'b0, '0});
        script.push_back('{req_of(ACT_NEXT_READ, 0, 0, 0, 0, 0, 0), 1'b0, '0});
        script.push_back('{req_of(ACT_DRAIN, 0, 0, 0, 0, 1, 0), 1'b0, '0});
        script.push_back('{req_of(ACT_NEXT_READ, 0, 0, 0, 0, 0, 0), 1'b0, '0});
        script.push_back('{req_of(ACT_DRAIN, 0, 0, 0, 0, 1, 0), 1'b0, '0});
        script.push_back('{req_of(ACT_CURSOR, 0, 24'h123456, 0, 0, 0, 0), 1'b0, '0});
        script.push_back('{req_of(ACT_RECORD, 100, 0, 0, 0, 0, 0), 1'b0, '0});
        script.push_back('{req_of(ACT_PREPARE, '1, 0, 1, 1, 1, 0), 1'b0, '0});
        script.push_back('{req_of(ACT_DRAIN, 0, 0, 0, 0, 1, '1), 1'b0, '0});
        script.push_back('{req_of(ACT_PREPARE, 0, 0, 1, 0, 0, 0), 1'b0, '0});

        plan[0] = '{max_blocks: 7'd3, block_size: 24'd200, policy: POL_OLDEST,
                    threshold: 31'd500};
        plan[1] = '{max_blocks: 7'd99, block_size: 24'hFFFFFF, policy: POL_OLDEST,
                    threshold: 31'd1660944285};
        plan[2] = '{max_blocks: 7'd0, block_size: 24'd1, policy: POL_OLDEST,
                    threshold: 31'd0};
        plan[3] = '{max_blocks: 7'd4, block_size: 24'd64, policy: POL_REJECT,
                    threshold: 31'd100};
        plan[4] = '{max_blocks: 7'd127, block_size: 24'd300, policy: POL_RESERVED,
                    threshold: 31'd1000};
        plan[5] = '{max_blocks: 7'd2, block_size: 24'd4096, policy: POL_HALT,
                    threshold: 31'd8192};

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (script[i]) send_action(script[i].req, script[i].fixed, script[i].want);
        directed = sent;

        for (int p = 0; p < PHASES; p++) begin
            settle();
            apb_write(REG_MAX_BLOCKS, APB_DW'(plan[p].max_blocks));
            apb_write(REG_BLOCK_SIZE, APB_DW'(plan[p].block_size));
            apb_write(REG_POLICY, APB_DW'(plan[p].policy));
            apb_write(REG_THRESHOLD, APB_DW'(plan[p].threshold));
            for (int k = 0; k < RANDOM_PER_PHASE; k++) send_action(draw_req(), 1'b0, '0);
        end

        s_valid <= 1'b0;
        while (status_due.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        $display("sent %0d actions (%0d directed) across %0d register settings plus reset",
                 sent, directed, PHASES);
        $display("checked %0d status transactions, %0d field mismatches",
                 statuses_seen, mismatches);
        if (mismatches == 0 && status_due.size() == 0) begin
            $display("tb_block_ring_store_manager_core: PASS");
        end else begin
            $display("tb_block_ring_store_manager_core: FAIL");
        end
        $finish;
    end

endmodule
